// ----- sv/cia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CIA register block package
// Types, register offsets and codes shared by the CIA register block modules.
// ----------------------------------------------------------------------------
package cia_pkg;

  // Kind of a transfer on the input channel.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } cia_kind_e;

  // Configuration register indexes.
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_IRQ_ENABLE   = 1'b1;

  localparam logic [15:0] BASE_ADDRESS_RESET = 16'hDC00;

  // Register offsets within the sixteen-byte window.
  localparam logic [3:0] OFF_PRA  = 4'd0;
  localparam logic [3:0] OFF_PRB  = 4'd1;
  localparam logic [3:0] OFF_DDRA = 4'd2;
  localparam logic [3:0] OFF_DDRB = 4'd3;
  localparam logic [3:0] OFF_TALO = 4'd4;
  localparam logic [3:0] OFF_TAHI = 4'd5;
  localparam logic [3:0] OFF_TBLO = 4'd6;
  localparam logic [3:0] OFF_TBHI = 4'd7;
  localparam logic [3:0] OFF_TOD0 = 4'd8;
  localparam logic [3:0] OFF_TOD1 = 4'd9;
  localparam logic [3:0] OFF_TOD2 = 4'd10;
  localparam logic [3:0] OFF_TOD3 = 4'd11;
  localparam logic [3:0] OFF_SDR  = 4'd12;
  localparam logic [3:0] OFF_ICR  = 4'd13;
  localparam logic [3:0] OFF_CRA  = 4'd14;
  localparam logic [3:0] OFF_CRB  = 4'd15;

  // Timer B count sources that actually count.
  localparam logic [1:0] SRC_B_CYCLES = 2'd0;
  localparam logic [1:0] SRC_B_TA     = 2'd2;

  // Interrupt flag bits kept when the interrupt register is read.
  localparam logic [7:0] ICR_READ_KEEP = 8'h18;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  elapsed_cycles;
  } cia_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic [7:0] port_b_value;
  } cia_out_t;

  // Status of one timer step.
  typedef struct packed {
    logic        under;
    logic [15:0] count;
  } cia_tmr_res_t;

endpackage
`default_nettype wire

// ----- sv/cia_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CIA down-timer step
// Subtracts a decrement from a 16-bit count, detects underflow and picks the
// next count (difference, or latch value when the timer reloads).
// ----------------------------------------------------------------------------
module cia_timer (
  input  logic                  en_i,
  input  logic [15:0]           count_i,
  input  logic [15:0]           reload_i,
  input  logic                  one_shot_i,
  input  logic [7:0]            dec_i,
  output cia_pkg::cia_tmr_res_t res_o
);
  import cia_pkg::*;

  logic [16:0] diff;
  logic        under;

  // Signed difference: underflow when it is zero or negative.
  assign diff  = {1'b0, count_i} - {9'b0, dec_i};
  assign under = en_i && (diff[16] || (diff == 17'd0));

  always_comb begin
    res_o.under = under;
    if (!en_i) begin
      res_o.count = count_i;
    end else if (under && !one_shot_i) begin
      res_o.count = reload_i;
    end else begin
      res_o.count = diff[15:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/cia_timer_register_block_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CIA timer and register block
// Sixteen-register CIA-style peripheral with ports, two down-timers, TOD
// bytes, serial byte and interrupt flags, driven by read, write and tick
// transfers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_data_i  (cia_in_t)
// out       output     out_valid_o/out_ready_i out_data_o (cia_out_t)
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Each transfer is registered, then executed against the register state into
// the result register: one result per transfer, one transfer per cycle
// sustained while results are taken.
// Reset clears all register state; base address returns to 0xDC00 and the
// interrupt enable to one.
// A stalled result holds the execute stage; the input register then fills
// and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module cia_timer_register_block_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cia_pkg::cia_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cia_pkg::cia_out_t out_data_o
);
  import cia_pkg::*;

  // Configuration.
  logic [15:0] base_q;
  logic        irq_en_q;

  // Pipeline.
  logic     s1_valid_q;
  cia_in_t  s1_q;
  logic     out_valid_q;
  cia_out_t out_q, out_d;
  logic     advance;

  // Register state.
  logic [7:0]  pra_q, pra_d, prb_q, prb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [15:0] cnta_q, cnta_d, cntb_q, cntb_d, rlda_q, rlda_d, rldb_q, rldb_d;
  logic [7:0]  cra_q, cra_d, crb_q, crb_d;
  logic        runa_q, runa_d, runb_q, runb_d, srca_q, srca_d;
  logic [1:0]  srcb_q, srcb_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  tod_q [4];
  logic [7:0]  tod_d [4];
  logic [7:0]  sdr_q, sdr_d;

  // Address decode.
  logic [16:0] rel;
  logic        mapped;
  logic [3:0]  off;

  // Timers.
  logic         ta_en, tb_en;
  logic [7:0]   tb_dec;
  cia_tmr_res_t ta_res, tb_res;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_ADDRESS_RESET;
      irq_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BASE_ADDRESS) begin
        base_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_IRQ_ENABLE) begin
        irq_en_q <= cfg_data_i[0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // Address window check without wrap-around.
  assign rel    = {1'b0, s1_q.address} - {1'b0, base_q};
  assign mapped = !rel[16] && (rel[15:4] == 12'd0);
  assign off    = rel[3:0];

  // Timer steps: A first, B may count A underflows of this tick.
  assign ta_en  = (s1_q.kind == KIND_TICK) && runa_q && !srca_q;
  assign tb_en  = (s1_q.kind == KIND_TICK) && runb_q &&
                  ((srcb_q == SRC_B_CYCLES) || (srcb_q == SRC_B_TA));
  assign tb_dec = (srcb_q == SRC_B_TA) ? {7'd0, ta_res.under} : s1_q.elapsed_cycles;

  cia_timer u_timer_a (
    .en_i       (ta_en),
    .count_i    (cnta_q),
    .reload_i   (rlda_q),
    .one_shot_i (cra_q[3]),
    .dec_i      (s1_q.elapsed_cycles),
    .res_o      (ta_res)
  );

  cia_timer u_timer_b (
    .en_i       (tb_en),
    .count_i    (cntb_q),
    .reload_i   (rldb_q),
    .one_shot_i (crb_q[3]),
    .dec_i      (tb_dec),
    .res_o      (tb_res)
  );

  // Execute one transfer against the register state.
  always_comb begin
    pra_d   = pra_q;
    prb_d   = prb_q;
    ddra_d  = ddra_q;
    ddrb_d  = ddrb_q;
    cnta_d  = cnta_q;
    cntb_d  = cntb_q;
    rlda_d  = rlda_q;
    rldb_d  = rldb_q;
    cra_d   = cra_q;
    crb_d   = crb_q;
    runa_d  = runa_q;
    runb_d  = runb_q;
    srca_d  = srca_q;
    srcb_d  = srcb_q;
    flags_d = flags_q;
    tod_d   = tod_q;
    sdr_d   = sdr_q;
    out_d.read_data = 8'd0;
    out_d.irq_pulse = 1'b0;

    case (s1_q.kind)
      KIND_READ: begin
        if (mapped) begin
          case (off)
            OFF_PRA:  out_d.read_data = pra_q;
            OFF_PRB:  out_d.read_data = prb_q;
            OFF_DDRA: out_d.read_data = ddra_q;
            OFF_DDRB: out_d.read_data = ddrb_q;
            OFF_TALO: out_d.read_data = cnta_q[7:0];
            OFF_TAHI: out_d.read_data = cnta_q[15:8];
            OFF_TBLO: out_d.read_data = cntb_q[7:0];
            OFF_TBHI: out_d.read_data = cntb_q[15:8];
            OFF_TOD0: out_d.read_data = tod_q[0] & 8'h0F;
            OFF_TOD1: out_d.read_data = tod_q[1] & 8'h7F;
            OFF_TOD2: out_d.read_data = tod_q[2] & 8'h7F;
            OFF_TOD3: out_d.read_data = tod_q[3];
            OFF_SDR:  out_d.read_data = sdr_q;
            OFF_ICR: begin
              out_d.read_data = flags_q;
              flags_d         = flags_q & ICR_READ_KEEP;
            end
            OFF_CRA:  out_d.read_data = cra_q;
            default:  out_d.read_data = crb_q;
          endcase
        end
      end
      KIND_WRITE: begin
        if (mapped) begin
          case (off)
            OFF_PRA:  pra_d  = s1_q.write_data;
            OFF_PRB:  prb_d  = s1_q.write_data;
            OFF_DDRA: ddra_d = s1_q.write_data;
            OFF_DDRB: ddrb_d = s1_q.write_data;
            OFF_TALO: rlda_d = {rlda_q[15:8], s1_q.write_data};
            OFF_TAHI: begin
              rlda_d = {s1_q.write_data, rlda_q[7:0]};
              if (!runa_q) begin
                cnta_d = {s1_q.write_data, rlda_q[7:0]};
              end
            end
            OFF_TBLO: rldb_d = {rldb_q[15:8], s1_q.write_data};
            OFF_TBHI: begin
              rldb_d = {s1_q.write_data, rldb_q[7:0]};
              if (!runb_q) begin
                cntb_d = {s1_q.write_data, rldb_q[7:0]};
              end
            end
            OFF_TOD0, OFF_TOD1, OFF_TOD2, OFF_TOD3: tod_d[off[1:0]] = s1_q.write_data;
            OFF_SDR:  sdr_d = s1_q.write_data;
            OFF_ICR: begin
              flags_d = (flags_q | {(s1_q.write_data[2:0] != 3'd0), 7'd0}) &
                        ~s1_q.write_data;
            end
            OFF_CRA: begin
              runa_d = s1_q.write_data[0];
              if (s1_q.write_data[4]) begin
                cnta_d = rlda_q;
              end
              srca_d = s1_q.write_data[5];
              cra_d  = s1_q.write_data;
            end
            default: begin
              runb_d = s1_q.write_data[0];
              if (s1_q.write_data[4]) begin
                cntb_d = rldb_q;
              end
              srcb_d = s1_q.write_data[6:5];
              crb_d  = s1_q.write_data;
            end
          endcase
        end
      end
      KIND_TICK: begin
        cnta_d = ta_res.count;
        cntb_d = tb_res.count;
        if (ta_res.under) begin
          prb_d[6]   = cra_q[2] ? ~prb_q[6] : 1'b1;
          flags_d[0] = 1'b1;
          if (cra_q[3]) begin
            cra_d[0] = 1'b0;
            runa_d   = 1'b0;
          end
        end
        if (tb_res.under) begin
          prb_d[7]   = crb_q[2] ? ~prb_q[7] : 1'b1;
          flags_d[1] = 1'b1;
          if (crb_q[3]) begin
            crb_d[0] = 1'b0;
            runb_d   = 1'b0;
          end
        end
        out_d.irq_pulse = (ta_res.under || tb_res.under) && irq_en_q;
      end
      default: begin
      end
    endcase
    out_d.port_b_value = prb_d;
  end

  // State update on execute.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pra_q   <= 8'd0;
      prb_q   <= 8'd0;
      ddra_q  <= 8'd0;
      ddrb_q  <= 8'd0;
      cnta_q  <= 16'd0;
      cntb_q  <= 16'd0;
      rlda_q  <= 16'd0;
      rldb_q  <= 16'd0;
      cra_q   <= 8'd0;
      crb_q   <= 8'd0;
      runa_q  <= 1'b0;
      runb_q  <= 1'b0;
      srca_q  <= 1'b0;
      srcb_q  <= 2'd0;
      flags_q <= 8'd0;
      tod_q   <= '{default: 8'd0};
      sdr_q   <= 8'd0;
    end else if (advance) begin
      pra_q   <= pra_d;
      prb_q   <= prb_d;
      ddra_q  <= ddra_d;
      ddrb_q  <= ddrb_d;
      cnta_q  <= cnta_d;
      cntb_q  <= cntb_d;
      rlda_q  <= rlda_d;
      rldb_q  <= rldb_d;
      cra_q   <= cra_d;
      crb_q   <= crb_d;
      runa_q  <= runa_d;
      runb_q  <= runb_d;
      srca_q  <= srca_d;
      srcb_q  <= srcb_d;
      flags_q <= flags_d;
      tod_q   <= tod_d;
      sdr_q   <= sdr_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // A full input register behind a stalled result blocks new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are held");

  // Reading the interrupt register clears every flag but bits 3 and 4.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_q.kind == KIND_READ) && mapped && (off == OFF_ICR))
    |=> ((flags_q & ~ICR_READ_KEEP) == 8'd0))
    else $error("interrupt flags not cleared by read");

  // A one-shot timer A stops on underflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ta_res.under && cra_q[3]) |=> (!runa_q && !cra_q[0]))
    else $error("one-shot timer A still running after underflow");

  // Anything but a read returns zero read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_q.kind != KIND_READ)) |=> (out_data_o.read_data == 8'd0))
    else $error("read data not zero on a non-read transfer");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIA timer and register block testbench
// Sends read, write and tick transfers through the valid/ready input, works
// out each result with a behavioural copy of the register block and compares
// it field by field with what leaves the output channel. Runs under several
// base address and interrupt enable settings and several stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import cia_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  cia_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  cia_out_t    out_data_o;

  cia_timer_register_block_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Transfers waiting to be offered and results waiting to arrive.
  cia_in_t  pending_items_q[$];
  cia_out_t expected_results_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int long_hold_req = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int pulses_predicted = 0;
  int settings_used = 0;
  int mismatch_count = 0;

  // Shadow copy of the register block state and its configuration.
  logic [15:0] base_mirror;
  logic        irq_en_mirror;
  logic [7:0]  pra, prb, ddra, ddrb, cra, crb, icr, sdr;
  logic [15:0] cnt_a, cnt_b, latch_a, latch_b;
  logic        run_a, run_b, src_a;
  logic [1:0]  src_b;
  logic [7:0]  tod [4];

  task automatic clear_shadow();
    base_mirror   = BASE_ADDRESS_RESET;
    irq_en_mirror = 1'b1;
    pra = '0; prb = '0; ddra = '0; ddrb = '0; cra = '0; crb = '0; icr = '0; sdr = '0;
    cnt_a = '0; cnt_b = '0; latch_a = '0; latch_b = '0;
    run_a = 1'b0; run_b = 1'b0; src_a = 1'b0; src_b = '0;
    for (int i = 0; i < 4; i++) tod[i] = '0;
  endtask

  // One timer decrement; an underflow marks port B, flags it and then
  // either stops the timer (one-shot) or reloads it from its latch.
  task automatic step_timer(inout logic [15:0] cnt, inout logic [7:0] ctl, inout logic run,
                            input logic [15:0] latch, input logic [7:0] dec,
                            input int pb_bit, input int flag_bit, output logic under);
    logic signed [17:0] diff;
    diff  = $signed({2'b00, cnt}) - $signed({10'd0, dec});
    cnt   = diff[15:0];
    under = (diff <= 0);
    if (under) begin
      if (ctl[2]) prb[pb_bit] = ~prb[pb_bit];
      else prb[pb_bit] = 1'b1;
      icr[flag_bit] = 1'b1;
      if (ctl[3]) begin
        ctl[0] = 1'b0;
        run    = 1'b0;
      end else begin
        run = 1'b1;
        cnt = latch;
      end
    end
  endtask

  // Register read; reading the interrupt register clears most flags.
  function automatic logic [7:0] read_reg(input logic [3:0] off);
    logic [7:0] v;
    case (off)
      OFF_PRA:  v = pra;
      OFF_PRB:  v = prb;
      OFF_DDRA: v = ddra;
      OFF_DDRB: v = ddrb;
      OFF_TALO: v = cnt_a[7:0];
      OFF_TAHI: v = cnt_a[15:8];
      OFF_TBLO: v = cnt_b[7:0];
      OFF_TBHI: v = cnt_b[15:8];
      OFF_TOD0: v = tod[0] & 8'h0F;
      OFF_TOD1: v = tod[1] & 8'h7F;
      OFF_TOD2: v = tod[2] & 8'h7F;
      OFF_TOD3: v = tod[3];
      OFF_SDR:  v = sdr;
      OFF_ICR: begin
        v   = icr;
        icr = icr & ICR_READ_KEEP;
      end
      OFF_CRA:  v = cra;
      default:  v = crb;
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [3:0] off, input logic [7:0] d);
    case (off)
      OFF_PRA:  pra = d;
      OFF_PRB:  prb = d;
      OFF_DDRA: ddra = d;
      OFF_DDRB: ddrb = d;
      OFF_TALO: latch_a[7:0] = d;
      OFF_TAHI: begin
        latch_a[15:8] = d;
        if (!run_a) cnt_a = latch_a;
      end
      OFF_TBLO: latch_b[7:0] = d;
      OFF_TBHI: begin
        latch_b[15:8] = d;
        if (!run_b) cnt_b = latch_b;
      end
      // The four time-of-day bytes sit at offsets 8 to 11.
      OFF_TOD0, OFF_TOD1, OFF_TOD2, OFF_TOD3: tod[off[1:0]] = d;
      OFF_SDR:  sdr = d;
      OFF_ICR: begin
        if (d[2:0] != 3'd0) icr[7] = 1'b1;
        icr = icr & ~d;
      end
      OFF_CRA: begin
        run_a = d[0];
        if (d[4]) cnt_a = latch_a;
        src_a = d[5];
        cra   = d;
      end
      default: begin
        run_b = d[0];
        if (d[4]) cnt_b = latch_b;
        src_b = d[6:5];
        crb   = d;
      end
    endcase
  endtask

  // Works out the result of one transfer and advances the shadow state.
  task automatic predict_cia_result(input cia_in_t item, output cia_out_t res);
    logic [16:0] span;
    logic        mapped;
    logic        under_a;
    logic        under_b;
    span    = {1'b0, item.address} - {1'b0, base_mirror};
    mapped  = (item.address >= base_mirror) && (span < 17'd16);
    under_a = 1'b0;
    under_b = 1'b0;
    res     = '0;
    case (cia_kind_e'(item.kind))
      KIND_READ:  if (mapped) res.read_data = read_reg(span[3:0]);
      KIND_WRITE: if (mapped) write_reg(span[3:0], item.write_data);
      KIND_TICK: begin
        // Timer A first, so that timer B can count its underflow.
        if (run_a && !src_a)
          step_timer(cnt_a, cra, run_a, latch_a, item.elapsed_cycles, 6, 0, under_a);
        if (run_b && src_b == SRC_B_CYCLES)
          step_timer(cnt_b, crb, run_b, latch_b, item.elapsed_cycles, 7, 1, under_b);
        else if (run_b && src_b == SRC_B_TA)
          step_timer(cnt_b, crb, run_b, latch_b, {7'd0, under_a}, 7, 1, under_b);
        res.irq_pulse = (under_a || under_b) && irq_en_mirror;
      end
      default: ;
    endcase
    res.port_b_value = prb;
  endtask

  function automatic cia_in_t make_item(input cia_kind_e k, input logic [15:0] addr,
                                        input logic [7:0] d, input logic [7:0] elapsed);
    cia_in_t it;
    it.kind           = k;
    it.address        = addr;
    it.write_data     = d;
    it.elapsed_cycles = elapsed;
    return it;
  endfunction

  // Random transfer, mostly inside the window; timer latches are kept small
  // and the run bits mostly set so that underflows happen often.
  function automatic cia_in_t random_item();
    cia_in_t     it;
    int unsigned sel;
    logic [3:0]  off;
    sel = $urandom_range(99);
    if (sel < 40) it.kind = KIND_WRITE;
    else if (sel < 65) it.kind = KIND_READ;
    else if (sel < 97) it.kind = KIND_TICK;
    else it.kind = KIND_NONE;
    off = 4'($urandom_range(15));
    sel = $urandom_range(99);
    if (sel < 85) it.address = base_mirror + {12'd0, off};
    else if (sel < 90) it.address = base_mirror - 16'd1;
    else if (sel < 95) it.address = base_mirror + 16'd16;
    else it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    if ((off == OFF_TAHI || off == OFF_TBHI) && $urandom_range(9) < 7)
      it.write_data = 8'($urandom_range(1));
    if ((off == OFF_CRA || off == OFF_CRB) && $urandom_range(3) != 0)
      it.write_data[0] = 1'b1;
    it.elapsed_cycles = 8'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("MISMATCH at result %0d, %s: got %h, expected %h", results_seen, what, got, want);
  endtask

  task automatic check_result(input cia_out_t got);
    cia_out_t want;
    results_seen++;
    if (expected_results_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", got.read_data, 8'h00);
    end else begin
      want = expected_results_q.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.irq_pulse !== want.irq_pulse)
        report_mismatch("irq_pulse", {7'd0, got.irq_pulse}, {7'd0, want.irq_pulse});
      if (got.port_b_value !== want.port_b_value)
        report_mismatch("port_b_value", got.port_b_value, want.port_b_value);
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: offers queued transfers, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    cia_out_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_cia_result(in_data_i, res);
        expected_results_q.push_back(res);
        items_accepted++;
        if (res.irq_pulse) pulses_predicted++;
      end
      if (pending_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result transfer and stalls at random, with
  // an occasional long hold-off so that the block backs up.
  int hold_left;
  int holds_seen;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      holds_seen  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) check_result(out_data_o);
      if (long_hold_req != holds_seen) begin
        holds_seen  <= long_hold_req;
        hold_left   <= LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when work is outstanding but nothing moves.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) &&
        (pending_items_q.size() != 0 || in_valid_i || expected_results_q.size() != 0)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer", quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Waits until every queued transfer has gone in and every result is back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items_q.size() != 0 || in_valid_i || expected_results_q.size() != 0);
  endtask

  // Configuration write, only issued while the block is idle.
  task automatic write_cfg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) base_mirror = val;
    else irq_en_mirror = val[0];
  endtask

  // One setting and stall pattern, fed in chunks; between chunks the
  // sender waits for every outstanding result.
  task automatic run_segment(input int s_pct, input int r_pct, input logic [15:0] base,
                             input logic irq_on, input int n_items, input bit with_hold);
    int pushed;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_cfg(CFG_BASE_ADDRESS, base);
    write_cfg(CFG_IRQ_ENABLE, {15'd0, irq_on});
    settings_used++;
    @(negedge clk_i);
    if (with_hold) long_hold_req++;
    pushed = 0;
    while (pushed < n_items) begin
      pending_items_q.push_back(random_item());
      pushed++;
      if (pushed % 60 == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Stimulus sequence.
  initial begin
    logic [15:0] b;
    logic [15:0] rand_base;
    clear_shadow();
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_BASE_ADDRESS;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset settings.
    send_idle_pct = 27;
    recv_idle_pct = 78;
    write_cfg(CFG_BASE_ADDRESS, BASE_ADDRESS_RESET);
    write_cfg(CFG_IRQ_ENABLE, 16'd1);
    settings_used++;
    @(negedge clk_i);
    b = base_mirror;
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_PRA, 8'hFF, 8'h00));
    pending_items_q.push_back(make_item(KIND_READ,  b + OFF_PRA, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TALO, 8'h03, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TAHI, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TBLO, 8'h01, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TBHI, 8'h00, 8'h00));
    // Timer B counting timer A underflows, timer A free running.
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_CRB, 8'h41, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_CRA, 8'h01, 8'h00));
    pending_items_q.push_back(make_item(KIND_TICK,  16'h0000, 8'h00, 8'h02));
    pending_items_q.push_back(make_item(KIND_TICK,  16'hFFFF, 8'hFF, 8'hFF));
    pending_items_q.push_back(make_item(KIND_READ,  b + OFF_ICR, 8'h00, 8'h00));
    // One-shot with toggle: underflow flips port B bit 6 and stops timer A.
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_CRA, 8'h0D, 8'h00));
    pending_items_q.push_back(make_item(KIND_TICK,  b, 8'h00, 8'hFF));
    pending_items_q.push_back(make_item(KIND_READ,  b + OFF_CRA, 8'h00, 8'h00));
    // A running timer sitting at zero underflows on a zero-cycle tick.
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TALO, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TAHI, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_CRA, 8'h01, 8'h00));
    pending_items_q.push_back(make_item(KIND_TICK,  b, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_ICR, 8'h07, 8'h00));
    pending_items_q.push_back(make_item(KIND_READ,  b + OFF_ICR, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + OFF_TOD1, 8'hFF, 8'h00));
    pending_items_q.push_back(make_item(KIND_READ,  b + OFF_TOD1, 8'h00, 8'h00));
    // Addresses just outside the window, and the unused kind.
    pending_items_q.push_back(make_item(KIND_READ,  b - 16'd1, 8'h00, 8'h00));
    pending_items_q.push_back(make_item(KIND_WRITE, b + 16'd16, 8'hFF, 8'h00));
    pending_items_q.push_back(make_item(KIND_NONE,  16'hFFFF, 8'hFF, 8'hFF));
    wait_drained();

    // Random part over several settings and stall patterns.
    run_segment(27, 78, 16'hDC00, 1'b1, 200, 1'b0);
    run_segment(78, 27, 16'h0000, 1'b0, 200, 1'b0);
    run_segment(0, 0, 16'hFFFF, 1'b1, 80, 1'b1);
    rand_base = 16'($urandom_range(16'hFFF0));
    run_segment(0, 0, rand_base, 1'b1, 220, 1'b0);

    repeat (8) @(negedge clk_i);
    if (expected_results_q.size() != 0)
      report_mismatch("results never delivered", 8'(expected_results_q.size()), 8'h00);
    $display("Run covered %0d transfers and %0d results under %0d settings,",
             items_accepted, results_seen, settings_used);
    $display("including %0d interrupt pulses; %0d mismatches found.",
             pulses_predicted, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
